### rtl/flpte_pkg.sv
// Shared types and constants for the four-level page table engine.
// No dependencies.
package flpte_pkg;

    localparam int TABLE_FRAMES = 64;
    localparam int ENTRIES      = 512;
    localparam int IDX_W        = 9;
    localparam int FRAME_W      = $clog2(TABLE_FRAMES);
    localparam int NF_W         = $clog2(TABLE_FRAMES + 1);
    localparam int MEM_AW       = FRAME_W + IDX_W;
    localparam int PFN_W        = 40;

    localparam logic [1:0] MODE_MAP       = 2'd0;
    localparam logic [1:0] MODE_UNMAP     = 2'd1;
    localparam logic [1:0] MODE_TRANSLATE = 2'd2;

    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_NO_FRAMES   = 2'd2;

    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    localparam logic [63:0] LINK_FLAGS = 64'h7;
    localparam int          PRESENT_BIT = 0;
    localparam int          LARGE_BIT   = 7;

    typedef struct packed {
        logic load;
        logic rd;
        logic clr_step;
        logic clr_root;
        logic advance;
        logic set_missing;
        logic link;
        logic leaf;
        logic st_not_present;
        logic st_no_frames;
        logic addr_large;
        logic addr_leaf;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       present;
        logic       big_page;
        logic       in_pool;
        logic [1:0] lvl;
        logic [1:0] mode;
        logic [1:0] missing;
        logic       no_room;
        logic       clr_last;
        logic       init_last;
        logic       out_busy;
    } stat_t;

endpackage

### rtl/flpte_dpath.sv
// Datapath: table pool memory, request registers, allocator and result register.
// Depends on flpte_pkg.
module flpte_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  flpte_pkg::cmd_t       cmd,
    output flpte_pkg::stat_t      stat,
    input  logic                  cfg_we,
    input  logic [51:0]           cfg_wdata,
    input  logic [1:0]            mode,
    input  logic [47:0]           virt_addr,
    input  logic [51:0]           phys_addr,
    input  logic [63:0]           entry_flags,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [51:0]           translated_addr,
    output logic                  tlb_invalidate
);
    import flpte_pkg::*;

    logic [63:0]        mem [TABLE_FRAMES*ENTRIES];
    logic [51:0]        table_base_reg;
    logic [NF_W-1:0]    next_free_reg;
    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [FRAME_W-1:0] init_frame_reg;
    logic               out_valid_reg;
    logic [1:0]         mode_reg;
    logic [47:0]        va_reg;
    logic [51:0]        pa_reg;
    logic [63:0]        flags_reg;
    logic [FRAME_W-1:0] cur_reg;
    logic [1:0]         lvl_reg;
    logic [1:0]         missing_reg;
    logic [63:0]        rd_data_reg;
    logic [1:0]         res_status_reg;
    logic [51:0]        res_addr_reg;
    logic               res_tlb_reg;
    logic [1:0]         status_reg;
    logic [51:0]        addr_reg;
    logic               tlb_reg;

    logic [63:0]        entry;
    logic [IDX_W-1:0]   idx;
    logic [PFN_W-1:0]   diff;
    logic [FRAME_W-1:0] free_frame;
    logic [FRAME_W-1:0] clr_frame;
    logic [NF_W-1:0]    avail;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [63:0]        mem_wdata;
    logic [PFN_W-1:0]   link_pfn;

    assign entry      = rd_data_reg;
    assign diff       = entry[51:12] - table_base_reg[51:12];
    assign free_frame = next_free_reg[FRAME_W-1:0];
    assign clr_frame  = cmd.clr_root ? init_frame_reg : free_frame;
    assign avail      = NF_W'(TABLE_FRAMES) - next_free_reg;
    assign link_pfn   = table_base_reg[51:12] + PFN_W'(next_free_reg);

    always_comb
    begin
        unique case (lvl_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {cur_reg, idx};
        mem_wdata = 64'd0;
        priority if (cmd.clr_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = {clr_frame, clr_cnt_reg};
        end
        else if (cmd.link)
        begin
            mem_we    = 1'b1;
            mem_wdata = {12'd0, link_pfn, 12'd0} | LINK_FLAGS;
        end
        else if (cmd.leaf)
        begin
            mem_we    = 1'b1;
            if (mode_reg == MODE_MAP)
                mem_wdata = {12'd0, pa_reg[51:12], 12'd0} | flags_reg | 64'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.rd)
            rd_data_reg <= mem[{cur_reg, idx}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_base_reg <= '0;
            next_free_reg  <= NF_W'(1);
            clr_cnt_reg    <= '0;
            init_frame_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                table_base_reg <= cfg_wdata;
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            if (cmd.clr_root && stat.clr_last)
                init_frame_reg <= init_frame_reg + FRAME_W'(1);
            if (cmd.link)
                next_free_reg <= next_free_reg + NF_W'(1);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg       <= mode;
            va_reg         <= virt_addr;
            pa_reg         <= phys_addr;
            flags_reg      <= entry_flags;
            cur_reg        <= '0;
            lvl_reg        <= LVL_PML4;
            missing_reg    <= 2'd0;
            res_status_reg <= ST_DONE;
            res_addr_reg   <= '0;
            res_tlb_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.advance)
            begin
                cur_reg <= diff[FRAME_W-1:0];
                lvl_reg <= lvl_reg + 2'd1;
            end
            if (cmd.link)
            begin
                cur_reg     <= free_frame;
                lvl_reg     <= lvl_reg + 2'd1;
                missing_reg <= missing_reg - 2'd1;
            end
            if (cmd.set_missing)
                missing_reg <= LVL_PT - lvl_reg;
            if (cmd.leaf)
                res_tlb_reg <= 1'b1;
            if (cmd.st_not_present)
                res_status_reg <= ST_NOT_PRESENT;
            if (cmd.st_no_frames)
                res_status_reg <= ST_NO_FRAMES;
            if (cmd.addr_large)
                res_addr_reg <= {entry[51:21], va_reg[20:0]};
            if (cmd.addr_leaf)
                res_addr_reg <= {entry[51:12], va_reg[11:0]};
        end
        if (cmd.out_load)
        begin
            status_reg <= res_status_reg;
            addr_reg   <= res_addr_reg;
            tlb_reg    <= res_tlb_reg;
        end
    end

    assign stat.present   = entry[PRESENT_BIT];
    assign stat.big_page  = entry[LARGE_BIT];
    assign stat.in_pool   = diff < PFN_W'(TABLE_FRAMES);
    assign stat.lvl       = lvl_reg;
    assign stat.mode      = mode_reg;
    assign stat.missing   = missing_reg;
    assign stat.no_room   = NF_W'(missing_reg) > avail;
    assign stat.clr_last  = clr_cnt_reg == IDX_W'(ENTRIES - 1);
    assign stat.init_last = stat.clr_last && init_frame_reg == FRAME_W'(TABLE_FRAMES - 1);
    assign stat.out_busy  = out_valid_reg && !out_ready;

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign translated_addr = addr_reg;
    assign tlb_invalidate  = tlb_reg;

endmodule

### rtl/flpte_ctrl.sv
// Controller state machine: sequences walks, table allocation and clearing.
// Depends on flpte_pkg.
module flpte_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  flpte_pkg::stat_t  stat,
    output flpte_pkg::cmd_t   cmd
);
    import flpte_pkg::*;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_RD    = 9'b000000100,
        S_EV    = 9'b000001000,
        S_CHK   = 9'b000010000,
        S_CLR   = 9'b000100000,
        S_LINK  = 9'b001000000,
        S_LEAF  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = state_reg == S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                cmd.clr_root = 1'b1;
                if (stat.init_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (stat.mode == MODE_MAP || stat.mode == MODE_UNMAP
                    || stat.mode == MODE_TRANSLATE)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EV;
                end
                else
                    state_next = S_DONE;
            end
            S_EV:
            begin
                if (stat.mode == MODE_MAP)
                begin
                    if (!stat.present)
                    begin
                        cmd.set_missing = 1'b1;
                        state_next      = S_CHK;
                    end
                    else if (!stat.in_pool)
                    begin
                        cmd.st_not_present = 1'b1;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = (stat.lvl == LVL_PD) ? S_CHK : S_RD;
                    end
                end
                else if (stat.mode == MODE_UNMAP)
                begin
                    if (!stat.present || !stat.in_pool)
                    begin
                        cmd.st_not_present = 1'b1;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = (stat.lvl == LVL_PD) ? S_LEAF : S_RD;
                    end
                end
                else
                begin
                    if (!stat.present)
                    begin
                        cmd.st_not_present = 1'b1;
                        state_next         = S_DONE;
                    end
                    else if (stat.lvl == LVL_PD && stat.big_page)
                    begin
                        cmd.addr_large = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if (stat.lvl == LVL_PT)
                    begin
                        cmd.addr_leaf = 1'b1;
                        state_next    = S_DONE;
                    end
                    else if (!stat.in_pool)
                    begin
                        cmd.st_not_present = 1'b1;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_RD;
                    end
                end
            end
            S_CHK:
            begin
                if (stat.no_room)
                begin
                    cmd.st_no_frames = 1'b1;
                    state_next       = S_DONE;
                end
                else if (stat.missing == 2'd0)
                    state_next = S_LEAF;
                else
                    state_next = S_CLR;
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_LINK;
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                state_next = (stat.missing == 2'd1) ? S_LEAF : S_CLR;
            end
            S_LEAF:
            begin
                cmd.leaf   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

endmodule

### rtl/four_level_page_table_engine.sv
// Top level of the four-level page table engine.
// Depends on flpte_pkg, flpte_ctrl and flpte_dpath.
//
// Requests (mode, virt_addr, phys_addr, entry_flags) enter on in_valid/in_ready.
// Each request gives one result (status, translated_addr, tlb_invalidate) on
// out_valid/out_ready. cfg_we/cfg_wdata write table_base; write it only idle.
// One request at a time. Each level of the walk is one memory read followed by
// one evaluate. A map that creates tables, up to three of them, clears each
// new 512-entry frame entry by entry and then writes the link to it.
// The next request can be taken in the cycle after the result is loaded.
// After reset the whole pool, 64 frames of 512 entries, is cleared one entry
// at a time; in_ready stays low.
// The result sits in an output register: a new request is accepted while it
// waits, and the next result is held back until the receiver takes it.
module four_level_page_table_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [51:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [47:0] virt_addr,
    input  logic [51:0] phys_addr,
    input  logic [63:0] entry_flags,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [51:0] translated_addr,
    output logic        tlb_invalidate
);
    import flpte_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    flpte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    flpte_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mode            (mode),
        .virt_addr       (virt_addr),
        .phys_addr       (phys_addr),
        .entry_flags     (entry_flags),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .translated_addr (translated_addr),
        .tlb_invalidate  (tlb_invalidate)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    a_tlb_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tlb_invalidate |-> status == ST_DONE && translated_addr == '0)
        else $error("tlb flush on failed or translate request");

    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> translated_addr == '0)
        else $error("address returned with error status");

    a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> !cmd.clr_step && !cmd.link && !cmd.leaf)
        else $error("table write during walk read");

endmodule
